// ===== hdl/sps_pkg.sv =====
// Shared types and constants for the shared-pool multi-stack block.
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [2:0]         stack_id;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] pop_value;
   } rsp_type;

   localparam logic signed [31:0] POP_FAIL_VALUE = -32'sd1;
   localparam logic signed [31:0] PUSH_VALUE_OUT = 32'sd0;

endpackage

`default_nettype wire

// ===== hdl/sps_top_table.sv =====
// Stack top pointer memory with per-stack valid bits so that reset empties every stack at once.
`timescale 1ns / 1ps
`default_nettype none

module sps_top_table #(
   parameter int NUM_STACKS = 8,
   parameter int POOL_DEPTH = 64
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              rd_en,
   input  wire logic [(NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1)-1:0] rd_addr,
   output logic      [$clog2(POOL_DEPTH + 1)-1:0]                 rd_ptr,
   input  wire logic                                              wr_en,
   input  wire logic [(NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1)-1:0] wr_addr,
   input  wire logic [$clog2(POOL_DEPTH + 1)-1:0]                 wr_ptr
);

   localparam int PTR_W = $clog2(POOL_DEPTH + 1);
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

   logic [PTR_W-1:0]      top_mem [NUM_STACKS];
   logic [NUM_STACKS-1:0] valid_ff;
   logic [PTR_W-1:0]      rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         top_mem[wr_addr] <= wr_ptr;
      end
      if (rd_en) begin
         rd_data_ff <= top_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // A stack that was never written since reset is empty.
   assign rd_ptr = rd_valid_ff ? rd_data_ff : NULL_PTR;

endmodule

`default_nettype wire

// ===== hdl/shared_pool_multi_stack.sv =====
// Top level: several stacks sharing one linked pool of entries with a free list.
// Timing: a push or a pop of an empty stack has its result registered from the lookup state,
// a pop that finds an entry from the pop-read state after it. While busy no new word is taken,
// as the dependent reads (top pointer, then link and value) pass through registered RAMs.
// Reset: synchronous; all stacks empty and the free list restored at once through valid bits
// and a high-water count, so there is no clearing pass. Values are not reset.
`timescale 1ns / 1ps
`default_nettype none

module shared_pool_multi_stack
   import sps_pkg::*;
#(
   parameter int NUM_STACKS = 8,
   parameter int POOL_DEPTH = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_word,
   output logic         rsp_strobe,
   output rsp_type      rsp_word
);

   localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
   localparam int IDX_W  = $clog2(POOL_DEPTH);
   localparam int TOP_AW = NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_POP_READ
   } state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic [PTR_W-1:0] hwm_ff, hwm_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   // Latched request.
   opcode_type            op_ff;
   logic                  sid_ok_ff;
   logic [TOP_AW-1:0]     sid_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [PTR_W-1:0]      slot_ff;

   // Pool memories.
   logic [PTR_W-1:0]      link_mem  [POOL_DEPTH];
   logic [DATA_WIDTH-1:0] value_mem [POOL_DEPTH];
   logic [PTR_W-1:0]      link_q_ff;
   logic [DATA_WIDTH-1:0] value_q_ff;
   logic                  link_fresh_ff;
   logic [PTR_W-1:0]      link_addr_ff;

   logic                  accept;
   logic                  sid_ok;
   logic [PTR_W-1:0]      top_ptr;
   logic                  top_rd_en;
   logic                  top_wr_en;
   logic [PTR_W-1:0]      top_wr_ptr;
   logic                  link_rd_en;
   logic [PTR_W-1:0]      link_rd_ptr;
   logic                  link_wr_en;
   logic [PTR_W-1:0]      link_wr_ptr;
   logic [PTR_W-1:0]      link_wr_data;
   logic                  value_wr_en;
   logic [PTR_W-1:0]      link_eff;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign sid_ok = 32'(req_word.stack_id) < NUM_STACKS;

   // An entry at or above the high-water mark has never been linked since reset,
   // so its link is still the initial chain value, which is null for the last entry.
   assign link_eff = link_fresh_ff ? (link_addr_ff + PTR_W'(1)) : link_q_ff;

   sps_top_table #(
      .NUM_STACKS(NUM_STACKS),
      .POOL_DEPTH(POOL_DEPTH)
   ) u_top_table (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (top_rd_en),
      .rd_addr(TOP_AW'(req_word.stack_id)),
      .rd_ptr (top_ptr),
      .wr_en  (top_wr_en),
      .wr_addr(sid_ff),
      .wr_ptr (top_wr_ptr)
   );

   assign top_rd_en = accept && sid_ok;

   always_comb begin
      state_in      = state_ff;
      free_head_in  = free_head_ff;
      hwm_in        = hwm_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      top_wr_en     = 1'b0;
      top_wr_ptr    = free_head_ff;
      link_rd_en    = 1'b0;
      link_rd_ptr   = free_head_ff;
      link_wr_en    = 1'b0;
      link_wr_ptr   = free_head_ff;
      link_wr_data  = top_ptr;
      value_wr_en   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Fetch the free head's link in case this is a push.
               link_rd_en = (free_head_ff != NULL_PTR);
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (op_ff == OP_PUSH) begin
               rsp_strobe_in    = 1'b1;
               rsp_in.ok        = 1'b0;
               rsp_in.pop_value = PUSH_VALUE_OUT;
               state_in         = ST_IDLE;
               if (sid_ok_ff && free_head_ff != NULL_PTR) begin
                  value_wr_en  = 1'b1;
                  link_wr_en   = 1'b1;
                  link_wr_ptr  = free_head_ff;
                  link_wr_data = top_ptr;
                  top_wr_en    = 1'b1;
                  top_wr_ptr   = free_head_ff;
                  free_head_in = link_eff;
                  rsp_in.ok    = 1'b1;
                  if (free_head_ff == hwm_ff) begin
                     hwm_in = hwm_ff + PTR_W'(1);
                  end
               end
            end else begin
               if (sid_ok_ff && top_ptr != NULL_PTR) begin
                  link_rd_en  = 1'b1;
                  link_rd_ptr = top_ptr;
                  state_in    = ST_POP_READ;
               end else begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.ok        = 1'b0;
                  rsp_in.pop_value = POP_FAIL_VALUE;
                  state_in         = ST_IDLE;
               end
            end
         end
         ST_POP_READ: begin
            top_wr_en        = 1'b1;
            top_wr_ptr       = link_eff;
            link_wr_en       = 1'b1;
            link_wr_ptr      = slot_ff;
            link_wr_data     = free_head_ff;
            free_head_in     = slot_ff;
            rsp_strobe_in    = 1'b1;
            rsp_in.ok        = 1'b1;
            rsp_in.pop_value = 32'($signed(value_q_ff));
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= '0;
         hwm_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         hwm_ff        <= hwm_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff     <= req_word.opcode;
         sid_ok_ff <= sid_ok;
         sid_ff    <= TOP_AW'(req_word.stack_id);
         val_ff    <= DATA_WIDTH'($unsigned(req_word.push_value));
      end
      if (state_ff == ST_LOOKUP) begin
         slot_ff <= top_ptr;
      end
   end

   // Pool memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (link_wr_en) begin
         link_mem[link_wr_ptr[IDX_W-1:0]] <= link_wr_data;
      end
      if (value_wr_en) begin
         value_mem[free_head_ff[IDX_W-1:0]] <= val_ff;
      end
      if (link_rd_en) begin
         link_q_ff     <= link_mem[link_rd_ptr[IDX_W-1:0]];
         value_q_ff    <= value_mem[link_rd_ptr[IDX_W-1:0]];
         link_fresh_ff <= (link_rd_ptr >= hwm_ff);
         link_addr_ff  <= link_rd_ptr;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   // A popped entry was pushed before, so it lies below the high-water mark.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_READ) |-> !link_fresh_ff)
      else $error("pop read an entry that was never linked");

   assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= NULL_PTR && free_head_ff <= NULL_PTR)
      else $error("free list pointer or high-water mark out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(busy))
      else $error("result strobe without an operation in flight");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && !rsp_strobe_ff))
      else $error("accepted word did not occupy the block");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && op_ff == OP_PUSH) |=> (rsp_strobe_ff && !busy))
      else $error("push did not complete in its lookup cycle");

endmodule

`default_nettype wire
